// ===== sv/varint_zigzag_codec_core_defines.svh =====
// Assertion macros shared by the codec RTL.
`ifndef VARINT_ZIGZAG_CODEC_CORE_DEFINES_SVH
`define VARINT_ZIGZAG_CODEC_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define VZC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define VZC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define VZC_ASSERT(lbl, clk, rst_n, prop, msg)
`define VZC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/vzc_pkg.sv =====
`default_nettype none
package vzc_pkg;

    localparam int VALUE_W = 64;
    localparam int HALF_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 4;
    localparam int SHIFT_W = 6;

    localparam logic [BYTE_W-1:0]  CONT_BIT     = 8'h80;
    localparam logic [6:0]         GROUP_MASK   = 7'h7F;
    localparam logic [COUNT_W-1:0] LIMIT_NARROW = 4'd5;
    localparam logic [COUNT_W-1:0] LIMIT_WIDE   = 4'd10;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_VALUE    = 2'd1,
        KIND_OVERFLOW = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   byte_out;
        logic [VALUE_W-1:0]  value_out;
        logic                last;
    } t_result;

    typedef struct packed {
        logic                step;
        logic                wide;
        logic                sgn;
        logic [BYTE_W-1:0]   byte_in;
    } t_dec_req;

    function automatic logic [VALUE_W-1:0] zigzag_enc(input logic [VALUE_W-1:0] value,
                                                     input logic wide, input logic sgn);
        logic [HALF_W-1:0]  lo;
        logic [VALUE_W-1:0] res;
        lo = value[HALF_W-1:0];
        if (wide) begin
            res = sgn ? ({value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{value[VALUE_W-1]}}) : value;
        end else begin
            res = {{(VALUE_W-HALF_W){1'b0}},
                   sgn ? ({lo[HALF_W-2:0], 1'b0} ^ {HALF_W{lo[HALF_W-1]}}) : lo};
        end
        return res;
    endfunction

    function automatic logic [VALUE_W-1:0] zigzag_dec(input logic [VALUE_W-1:0] raw,
                                                     input logic wide, input logic sgn);
        logic [HALF_W-1:0]  lo;
        logic [HALF_W-1:0]  dlo;
        logic [VALUE_W-1:0] res;
        lo  = raw[HALF_W-1:0];
        dlo = {1'b0, lo[HALF_W-1:1]} ^ {HALF_W{lo[0]}};
        if (wide) begin
            res = sgn ? ({1'b0, raw[VALUE_W-1:1]} ^ {VALUE_W{raw[0]}}) : raw;
        end else if (sgn) begin
            res = {{(VALUE_W-HALF_W){dlo[HALF_W-1]}}, dlo};
        end else begin
            res = {{(VALUE_W-HALF_W){1'b0}}, lo};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== sv/vzc_decoder.sv =====
`default_nettype none
`include "varint_zigzag_codec_core_defines.svh"
module vzc_decoder
    import vzc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_dec_req i_req,
    output logic          o_hit,
    output t_result       o_result
);

    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;

    logic [SHIFT_W-1:0] shamt;
    logic [VALUE_W-1:0] acc_new;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] limit;
    logic               is_end;
    logic               ovf;

    always_comb begin
        shamt     = ({{(SHIFT_W-COUNT_W){1'b0}}, r_count} << 3)
                  - {{(SHIFT_W-COUNT_W){1'b0}}, r_count};
        acc_new   = r_acc | ({{(VALUE_W-7){1'b0}}, i_req.byte_in[6:0] & GROUP_MASK} << shamt);
        count_inc = r_count + 1'b1;
        limit     = i_req.wide ? LIMIT_WIDE : LIMIT_NARROW;
        is_end    = (i_req.byte_in & CONT_BIT) == '0;
        ovf       = !is_end && (count_inc >= limit);
        o_hit     = is_end || ovf;

        o_result.kind      = is_end ? KIND_VALUE : KIND_OVERFLOW;
        o_result.byte_out  = '0;
        o_result.value_out = zigzag_dec(acc_new, i_req.wide, i_req.sgn);
        o_result.last      = 1'b1;

        n_acc   = r_acc;
        n_count = r_count;
        if (i_req.step) begin
            if (o_hit) begin
                n_acc   = '0;
                n_count = '0;
            end else begin
                n_acc   = acc_new;
                n_count = count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_count <= '0;
        end else begin
            r_acc   <= n_acc;
            r_count <= n_count;
        end
    end

    `VZC_ASSERT(a_count_range, i_clk, i_rst_n, r_count < LIMIT_WIDE, "group count out of range")

endmodule
`default_nettype wire

// ===== sv/vzc_in_stage.sv =====
`default_nettype none
module vzc_in_stage
    import vzc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_func,
    input  wire logic               i_wide,
    input  wire logic               i_sgn,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [BYTE_W-1:0]  i_byte,
    input  wire logic               i_free,
    output t_dec_req                o_dec_req,
    input  wire logic               i_dec_hit,
    input  wire t_result            i_dec_result,
    output logic                    o_res_valid,
    output t_result                 o_result
);

    logic               r_valid;
    logic               n_valid;
    logic               r_func;
    logic               r_wide;
    logic               r_sgn;
    logic [VALUE_W-1:0] r_word;
    logic [VALUE_W-1:0] n_word;
    logic [BYTE_W-1:0]  r_byte;

    logic has_res;
    logic advance;
    logic enc_last;
    logic done;
    logic accept;

    always_comb begin
        enc_last = r_word[VALUE_W-1:7] == '0;
        has_res  = !r_func || i_dec_hit;
        advance  = r_valid && (!has_res || i_free);
        done     = advance && (r_func || enc_last);
        o_ready  = !r_valid || done;
        accept   = i_valid && o_ready;

        o_dec_req.step    = advance && r_func;
        o_dec_req.wide    = r_wide;
        o_dec_req.sgn     = r_sgn;
        o_dec_req.byte_in = r_byte;

        o_res_valid = advance && has_res;
        if (r_func) begin
            o_result = i_dec_result;
        end else begin
            o_result.kind      = KIND_BYTE;
            o_result.byte_out  = enc_last ? r_word[BYTE_W-1:0]
                                          : ({1'b0, r_word[6:0] & GROUP_MASK} | CONT_BIT);
            o_result.value_out = '0;
            o_result.last      = enc_last;
        end

        n_valid = r_valid;
        n_word  = r_word;
        if (accept) begin
            n_valid = 1'b1;
            n_word  = zigzag_enc(i_value, i_wide, i_sgn);
        end else if (done) begin
            n_valid = 1'b0;
        end else if (advance && !r_func) begin
            n_word = r_word >> 7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (accept) begin
            r_func <= i_func;
            r_wide <= i_wide;
            r_sgn  <= i_sgn;
            r_byte <= i_byte;
        end
    end

endmodule
`default_nettype wire

// ===== sv/vzc_out_reg.sv =====
`default_nettype none
module vzc_out_reg
    import vzc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_result,
    output logic         o_free,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ===== sv/varint_zigzag_codec_core.sv =====
// Base-128 varint codec with optional zigzag mapping for 32- and 64-bit values.
// The slave stream carries one command per beat: tuser selects encode or decode,
// the width and the zigzag mapping; tdata holds the value to encode and the byte
// to decode. The master stream returns encoded bytes (kind 0), decoded values
// (kind 1) or a partial value after an over-long run (kind 2), with tlast marking
// the final result caused by each command.
// An encode command yields one byte per cycle while the output register is free,
// 1 to 10 beats, and the next command is taken in the cycle of its final byte.
// A decode command yields a result only on the byte that ends a value or
// overflows, and a byte stream is decoded at one byte per cycle while the output
// register takes its results. The first result passes the input register and
// the output register. The decode accumulator and group count live between beats.
// Synchronous reset clears both registers' valid flags and the decoder state.
// When the receiver stalls, the output register holds its beat, the input
// register fills, and tready drops until the master side drains.
`default_nettype none
`include "varint_zigzag_codec_core_defines.svh"
module varint_zigzag_codec_core
    import vzc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,  // value_in[63:0], byte_in[71:64]
    input  wire logic [2:0]  i_s_tuser,  // func[0], wide[1], is_signed[2]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [71:0]      o_m_tdata,  // byte_out[7:0], value_out[71:8]
    output logic [1:0]       o_m_tuser,  // kind[1:0]
    output logic             o_m_tlast
);

    t_dec_req dec_req;
    logic     dec_hit;
    t_result  dec_result;
    logic     res_valid;
    t_result  stage_result;
    logic     out_free;
    t_result  out_result;

    vzc_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_func       (i_s_tuser[0]),
        .i_wide       (i_s_tuser[1]),
        .i_sgn        (i_s_tuser[2]),
        .i_value      (i_s_tdata[VALUE_W-1:0]),
        .i_byte       (i_s_tdata[VALUE_W+BYTE_W-1:VALUE_W]),
        .i_free       (out_free),
        .o_dec_req    (dec_req),
        .i_dec_hit    (dec_hit),
        .i_dec_result (dec_result),
        .o_res_valid  (res_valid),
        .o_result     (stage_result)
    );

    vzc_decoder u_decoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (dec_req),
        .o_hit    (dec_hit),
        .o_result (dec_result)
    );

    vzc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (res_valid),
        .i_result (stage_result),
        .o_free   (out_free),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (out_result)
    );

    assign o_m_tdata = {out_result.value_out, out_result.byte_out};
    assign o_m_tuser = out_result.kind;
    assign o_m_tlast = out_result.last;

    `VZC_ASSERT_IMP(a_byte_no_value, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_BYTE), o_m_tdata[71:8] == '0, "encoded byte beat carries a value")
    `VZC_ASSERT_IMP(a_value_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser != KIND_BYTE), (o_m_tdata[7:0] == '0) && o_m_tlast, "decoded beat has byte bits or no tlast")
    `VZC_ASSERT_IMP(a_cont_bit, i_clk, i_rst_n, o_m_tvalid && (o_m_tuser == KIND_BYTE), o_m_tdata[7] == !o_m_tlast, "continuation bit disagrees with tlast")

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import vzc_pkg::*;

    localparam logic FUNC_ENCODE  = 1'b0;
    localparam logic FUNC_DECODE  = 1'b1;
    localparam int   HALF_PERIOD  = 6;
    localparam int   LONG_HOLD    = 300;
    localparam int   ITEM_COUNT   = 260;
    localparam int   RUN_LIMIT    = 12 * 150000;

    typedef struct {
        logic        func;
        logic        wide;
        logic        sgn;
        logic [63:0] value_in;
        logic [7:0]  byte_in;
    } t_cmd;

    typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // Tracks the decoder state and the result beats each accepted command should produce.
    class varint_scoreboard;
        t_result     pending_results[$];
        logic [63:0] acc;
        logic [3:0]  groups;
        logic [7:0]  enc_bytes[10];
        int          mismatches;

        function new();
            acc        = '0;
            groups     = '0;
            mismatches = 0;
        endfunction

        // Fills enc_bytes with the varint groups of a value and returns their number.
        function int encode(logic [63:0] value, logic wide, logic sgn);
            logic [63:0] v;
            int          n;
            if (wide) begin
                v = sgn ? ((value << 1) ^ {64{value[63]}}) : value;
            end else begin
                v = {32'd0, value[31:0]};
                if (sgn) begin
                    v[31:0] = (value[31:0] << 1) ^ {32{value[31]}};
                end
            end
            n = 0;
            while (v >= 64'h80) begin
                enc_bytes[n] = {1'b1, v[6:0]};
                n++;
                v = v >> 7;
            end
            enc_bytes[n] = v[7:0];
            return n + 1;
        endfunction

        function logic [63:0] unzig(logic [63:0] raw, logic wide, logic sgn);
            logic [31:0] lo;
            if (wide) begin
                return sgn ? ((raw >> 1) ^ {64{raw[0]}}) : raw;
            end
            lo = sgn ? ((raw[31:0] >> 1) ^ {32{raw[0]}}) : raw[31:0];
            return sgn ? {{32{lo[31]}}, lo} : {32'd0, lo};
        endfunction

        function void take_command(t_cmd c);
            t_result    r;
            int         n;
            int         shift;
            logic [3:0] limit;
            r = '0;
            if (c.func == FUNC_ENCODE) begin
                n = encode(c.value_in, c.wide, c.sgn);
                for (int i = 0; i < n; i++) begin
                    r.kind     = KIND_BYTE;
                    r.byte_out = enc_bytes[i];
                    r.last     = (i == n - 1);
                    pending_results.insert(pending_results.size(), r);
                end
                return;
            end
            limit = c.wide ? LIMIT_WIDE : LIMIT_NARROW;
            shift = 7 * groups;
            if (shift > 63) begin
                shift = 63;
            end
            acc    = acc | ({57'd0, c.byte_in[6:0]} << shift);
            r.last = 1'b1;
            if (!c.byte_in[7]) begin
                r.kind = KIND_VALUE;
            end else begin
                groups = groups + 1'b1;
                if (groups < limit) begin
                    return;
                end
                r.kind = KIND_OVERFLOW;
            end
            r.value_out = unzig(acc, c.wide, c.sgn);
            pending_results.insert(pending_results.size(), r);
            acc    = '0;
            groups = '0;
        endfunction

        function void report(string what, t_result want, t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t mismatch in %s: expected kind=%0d byte=%02h value=%016h last=%0b",
                         $time, what, want.kind, want.byte_out, want.value_out, want.last);
                $display("    got kind=%0d byte=%02h value=%016h last=%0b",
                         got.kind, got.byte_out, got.value_out, got.last);
            end
        endfunction

        function void check_beat(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("unexpected beat", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                report("kind", want, got);
            end else if (got.byte_out !== want.byte_out) begin
                report("byte_out", want, got);
            end else if (got.value_out !== want.value_out) begin
                report("value_out", want, got);
            end else if (got.last !== want.last) begin
                report("last", want, got);
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [71:0] i_s_tdata  = '0;  // value_in[63:0], byte_in[71:64]
    logic [2:0]  i_s_tuser  = '0;  // func[0], wide[1], is_signed[2]
    logic        i_m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;        // byte_out[7:0], value_out[71:8]
    logic [1:0]  o_m_tuser;        // kind[1:0]
    logic        o_m_tlast;

    varint_scoreboard sb;
    t_cmd             cmd_q[$];

    varint_zigzag_codec_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic void add_enc(logic wide, logic sgn, logic [63:0] value);
        t_cmd c;
        c.func     = FUNC_ENCODE;
        c.wide     = wide;
        c.sgn      = sgn;
        c.value_in = value;
        c.byte_in  = 8'($urandom);
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    function automatic void add_dec(logic wide, logic sgn, logic [7:0] byte_in);
        t_cmd c;
        c.func     = FUNC_DECODE;
        c.wide     = wide;
        c.sgn      = sgn;
        c.value_in = {$urandom, $urandom};
        c.byte_in  = byte_in;
        cmd_q.insert(cmd_q.size(), c);
    endfunction

    // Half of the values are shortened or small negative ones so that all encoded lengths show up.
    function automatic logic [63:0] rand_value();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: v = v >> $urandom_range(0, 63);
            1: v = ~(v >> $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_cmd(input t_cmd c);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c.byte_in, c.value_in};
        i_s_tuser  <= {c.sgn, c.wide, c.func};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    always @(posedge i_clk) begin : monitor
        t_cmd    seen;
        t_result got;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            seen.func     = i_s_tuser[0];
            seen.wide     = i_s_tuser[1];
            seen.sgn      = i_s_tuser[2];
            seen.value_in = i_s_tdata[63:0];
            seen.byte_in  = i_s_tdata[71:64];
            sb.take_command(seen);
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.kind      = t_kind'(o_m_tuser);
            got.byte_out  = o_m_tdata[7:0];
            got.value_out = o_m_tdata[71:8];
            got.last      = o_m_tlast;
            sb.check_beat(got);
        end
    end

    // Two of the receiver's stretches are long hold-offs that back the block up to its input.
    initial begin : receiver
        int       seg;
        int       len;
        t_rx_mode mode;
        seg = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (seg == 4 || seg == 15) begin
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                len  = $urandom_range(10, 80);
                for (int k = 0; k < len; k++) begin
                    case (mode)
                        RX_OPEN:     i_m_tready <= 1'b1;
                        RX_BUSY:     i_m_tready <= ($urandom_range(0, 3) != 0);
                        RX_SPARSE:   i_m_tready <= ($urandom_range(0, 3) == 0);
                        RX_PERIODIC: i_m_tready <= (k % 4 != 3);
                        default:     i_m_tready <= 1'b1;
                    endcase
                    @(posedge i_clk);
                end
            end
            seg++;
        end
    end

    initial begin : stimulus
        int         target;
        int         pick;
        int         n;
        int         burst;
        int         gap;
        logic       wide;
        logic       sgn;
        logic       pad;
        logic [7:0] tail;
        sb = new();

        add_enc(1'b0, 1'b0, 64'd0);
        add_enc(1'b0, 1'b0, 64'hDEAD_BEEF_FFFF_FFFF);
        add_enc(1'b0, 1'b0, 64'd128);
        add_enc(1'b1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
        add_enc(1'b1, 1'b1, 64'h8000_0000_0000_0000);
        add_enc(1'b1, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
        add_enc(1'b0, 1'b1, 64'h0000_0000_8000_0000);
        add_enc(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        add_dec(1'b0, 1'b1, 8'h7F);
        add_dec(1'b1, 1'b0, 8'h00);
        // An encode in the middle of a value must not disturb the decoder.
        add_dec(1'b0, 1'b0, 8'h81);
        add_enc(1'b1, 1'b1, 64'h0123_4567_89AB_CDEF);
        add_dec(1'b0, 1'b0, 8'h01);
        repeat (5) add_dec(1'b0, 1'b1, 8'hFF);
        // Five 64-bit groups followed by a 32-bit continuation byte overflow at once.
        repeat (5) add_dec(1'b1, 1'b0, 8'h80);
        add_dec(1'b0, 1'b0, 8'h85);

        target = ITEM_COUNT;
        while (cmd_q.size() < target) begin
            pick = $urandom_range(0, 9);
            wide = 1'($urandom_range(0, 1));
            sgn  = 1'($urandom_range(0, 1));
            if (pick < 4) begin
                add_enc(wide, sgn, rand_value());
            end else if (pick < 8) begin
                n   = sb.encode(rand_value(), wide, sgn);
                pad = ($urandom_range(0, 5) == 0);
                if (pad) begin
                    sb.enc_bytes[n - 1] = sb.enc_bytes[n - 1] | CONT_BIT;
                end
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(0, 15) == 0) begin
                        add_enc(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                rand_value());
                    end
                    if ($urandom_range(0, 11) == 0) begin
                        wide = 1'($urandom_range(0, 1));
                        sgn  = 1'($urandom_range(0, 1));
                    end
                    add_dec(wide, sgn, sb.enc_bytes[i]);
                end
                if (pad) begin
                    add_dec(wide, sgn, 8'h00);
                end
            end else if (pick == 8) begin
                // A full-length run: either overflow or a top group with bits past the width.
                n = wide ? 10 : 5;
                repeat (n - 1) add_dec(wide, sgn, CONT_BIT | 8'($urandom));
                tail = 8'($urandom);
                add_dec(wide, sgn, tail);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    add_dec(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            8'($urandom));
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_q.size() > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && cmd_q.size() > 0) begin
                send_cmd(cmd_q.pop_front());
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("varint_zigzag_codec_core test passed");
        end else begin
            $display("varint_zigzag_codec_core test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT);
        $display("varint_zigzag_codec_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/vzc_pkg.sv
sv/vzc_decoder.sv
sv/vzc_in_stage.sv
sv/vzc_out_reg.sv
sv/varint_zigzag_codec_core.sv
tb/tb.sv
